// ----- hdl/tlps_pkg.sv -----
// Package for the two-level page table store: widths, opcodes, channel payloads,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package tlps_pkg;

    localparam int TABLE_COUNT_DEF = 16;
    localparam int ENTRIES_PER_TABLE = 1024;
    localparam int ADDR_W = 32;
    localparam int FRAME_W = 20;
    localparam int OFF_W = 12;
    localparam int IDX_W = 10;
    localparam int SIZE_W = 27;
    localparam int CNT_W = 15;

    localparam logic [IDX_W-1:0]  RECURSIVE_SLOT = 10'h3FF;
    localparam logic [SIZE_W-1:0] MAX_REGION = 27'h4000000;
    localparam logic [OFF_W-1:0]  PAGE_ROUND = 12'hFFF;
    localparam logic [OFF_W-1:0]  FLAG_PRESENT = 12'h001;
    localparam logic [OFF_W-1:0]  FLAGS_IDENTITY = 12'h003;

    typedef enum logic [1:0] {
        OP_MAP     = 2'd0,
        OP_XLATE   = 2'd1,
        OP_REBUILD = 2'd2,
        OP_NOP     = 2'd3
    } t_opcode;

    typedef enum logic [0:0] {
        CFG_TABLES_FRAME = 1'b0,
        CFG_DIR_FRAME    = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_opcode             opcode;
        logic [ADDR_W-1:0]   virt_addr;
        logic [ADDR_W-1:0]   phys_addr;
        logic [SIZE_W-1:0]   region_size;
        logic [OFF_W-1:0]    page_flags;
    } t_cmd;

    typedef struct packed {
        logic [ADDR_W-1:0]   result_addr;
        logic                dir_present;
        logic [CNT_W-1:0]    pages_written;
    } t_res;

    typedef struct packed {
        t_cfg_idx            index;
        logic [FRAME_W-1:0]  value;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_MAP,
        ST_REBUILD,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic latch;
        logic rd;
        logic sweep_wr;
        logic map_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic map_done;
        logic sweep_last;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- hdl/tlps_if.sv -----
// Valid/ready channel interfaces for the page table store: command in, result out,
// and the configuration write channel. Depends on tlps_pkg.
interface tlps_cmd_if;
    logic            valid;
    logic            ready;
    tlps_pkg::t_cmd  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tlps_res_if;
    logic            valid;
    logic            ready;
    tlps_pkg::t_res  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tlps_cfg_if;
    logic            valid;
    logic            ready;
    tlps_pkg::t_cfg  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/tlps_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module tlps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/tlps_ctrl.sv -----
// Controller state machine for the page table store: sequences init sweep,
// map walks, rebuilds and result hand-off. Depends on tlps_pkg.
module tlps_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  tlps_pkg::t_opcode  i_cmd_opcode,
    input  tlps_pkg::t_dp_sts  i_sts,
    output logic               o_cmd_ready,
    output tlps_pkg::t_dp_cmd  o_ctl
);

    tlps_pkg::t_state r_state;
    tlps_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlps_pkg::ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tlps_pkg::ST_INIT: begin
                if (i_sts.sweep_last) n_state = tlps_pkg::ST_IDLE;
            end
            tlps_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd_opcode) inside
                        tlps_pkg::OP_MAP:               n_state = tlps_pkg::ST_MAP;
                        tlps_pkg::OP_REBUILD:           n_state = tlps_pkg::ST_REBUILD;
                        tlps_pkg::OP_XLATE, tlps_pkg::OP_NOP: n_state = tlps_pkg::ST_FIN;
                        default:                        n_state = tlps_pkg::ST_FIN;
                    endcase
                end
            end
            tlps_pkg::ST_MAP: begin
                if (i_sts.map_done) n_state = tlps_pkg::ST_FIN;
            end
            tlps_pkg::ST_REBUILD: begin
                if (i_sts.sweep_last) n_state = tlps_pkg::ST_FIN;
            end
            tlps_pkg::ST_FIN: begin
                if (i_sts.out_free) n_state = tlps_pkg::ST_IDLE;
            end
            default: n_state = tlps_pkg::ST_INIT;
        endcase
    end

    always_comb begin
        o_ctl       = '0;
        o_cmd_ready = 1'b0;
        unique case (r_state) inside
            tlps_pkg::ST_INIT, tlps_pkg::ST_REBUILD: begin
                o_ctl.sweep_wr = 1'b1;
            end
            tlps_pkg::ST_IDLE: begin
                o_cmd_ready = 1'b1;
                o_ctl.latch = i_cmd_valid;
                o_ctl.rd    = i_cmd_valid;
            end
            tlps_pkg::ST_MAP: begin
                o_ctl.map_step = ~i_sts.map_done;
            end
            tlps_pkg::ST_FIN: begin
                o_ctl.load_out = i_sts.out_free;
            end
            default: ;
        endcase
    end

endmodule

// ----- hdl/tlps_dp.sv -----
// Datapath for the page table store: command registers, map walk counters, sweep
// counter, config registers, translate result logic and output register.
// Depends on tlps_pkg; drives the ports of the tlps_ram instance at the top level.
module tlps_dp #(
    parameter int TABLE_COUNT = tlps_pkg::TABLE_COUNT_DEF,
    parameter int RAM_AW = $clog2(TABLE_COUNT * tlps_pkg::ENTRIES_PER_TABLE)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tlps_pkg::t_cmd              i_cmd_data,
    input  logic                        i_cfg_we,
    input  tlps_pkg::t_cfg              i_cfg_data,
    input  tlps_pkg::t_dp_cmd           i_ctl,
    output tlps_pkg::t_dp_sts           o_sts,
    output logic                        o_ram_we,
    output logic [RAM_AW-1:0]           o_ram_waddr,
    output logic [tlps_pkg::ADDR_W-1:0] o_ram_wdata,
    output logic                        o_ram_re,
    output logic [RAM_AW-1:0]           o_ram_raddr,
    input  logic [tlps_pkg::ADDR_W-1:0] i_ram_rdata,
    input  logic                        i_res_ready,
    output logic                        o_res_valid,
    output tlps_pkg::t_res              o_res_data
);

    localparam int DEPTH = TABLE_COUNT * tlps_pkg::ENTRIES_PER_TABLE;
    localparam logic [tlps_pkg::IDX_W-1:0] DIR_LIM = tlps_pkg::IDX_W'(TABLE_COUNT);
    localparam logic [RAM_AW-1:0] SWEEP_LAST = RAM_AW'(DEPTH - 1);
    localparam logic [tlps_pkg::ADDR_W-1:0] PAGE_STEP = 32'h0000_1000;

    tlps_pkg::t_opcode                r_op;
    logic [tlps_pkg::ADDR_W-1:0]      r_virt;
    logic [tlps_pkg::ADDR_W-1:0]      r_phys;
    logic [tlps_pkg::OFF_W-1:0]       r_flags;
    logic [tlps_pkg::CNT_W-1:0]       r_left;
    logic [tlps_pkg::CNT_W-1:0]       r_written;
    logic [RAM_AW-1:0]                r_sweep;
    logic [tlps_pkg::FRAME_W-1:0]     r_tables_frame;
    logic [tlps_pkg::FRAME_W-1:0]     r_dir_frame;
    logic                             r_out_valid;
    tlps_pkg::t_res                   r_out;

    logic [tlps_pkg::SIZE_W-1:0]      size_sat;
    logic [tlps_pkg::SIZE_W:0]        size_round;
    logic [tlps_pkg::IDX_W-1:0]       map_dir;
    logic                             map_hit;
    logic [tlps_pkg::IDX_W-1:0]       xl_dir;
    logic [tlps_pkg::IDX_W-1:0]       xl_tab;
    logic [tlps_pkg::OFF_W-1:0]       xl_off;
    logic [tlps_pkg::FRAME_W-1:0]     slot_frame;
    tlps_pkg::t_res                   res;

    // Saturate the region and round up to whole pages.
    always_comb begin
        size_sat   = (i_cmd_data.region_size > tlps_pkg::MAX_REGION) ?
                     tlps_pkg::MAX_REGION : i_cmd_data.region_size;
        size_round = {1'b0, size_sat} + {{(tlps_pkg::SIZE_W + 1 - tlps_pkg::OFF_W){1'b0}},
                                         tlps_pkg::PAGE_ROUND};
    end

    assign map_dir = r_virt[31:22];
    assign map_hit = map_dir < DIR_LIM;

    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_op      <= i_cmd_data.opcode;
            r_virt    <= i_cmd_data.virt_addr;
            r_phys    <= i_cmd_data.phys_addr;
            r_flags   <= i_cmd_data.page_flags;
            r_left    <= size_round[tlps_pkg::SIZE_W-1:tlps_pkg::OFF_W];
            r_written <= '0;
        end else if (i_ctl.map_step) begin
            r_virt <= r_virt + PAGE_STEP;
            r_phys <= r_phys + PAGE_STEP;
            r_left <= r_left - tlps_pkg::CNT_W'(1);
            if (map_hit) r_written <= r_written + tlps_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else if (i_ctl.sweep_wr) begin
            r_sweep <= (r_sweep == SWEEP_LAST) ? '0 : r_sweep + RAM_AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tables_frame <= '0;
            r_dir_frame    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_data.index)
                tlps_pkg::CFG_TABLES_FRAME: r_tables_frame <= i_cfg_data.value;
                tlps_pkg::CFG_DIR_FRAME:    r_dir_frame    <= i_cfg_data.value;
                default: ;
            endcase
        end
    end

    // Memory port drive: sweep writes the identity entry, a map_hit step writes the new PTE.
    always_comb begin
        o_ram_we    = i_ctl.sweep_wr | (i_ctl.map_step & map_hit);
        o_ram_waddr = i_ctl.sweep_wr ? r_sweep : r_virt[RAM_AW+11:12];
        o_ram_wdata = i_ctl.sweep_wr ?
                      tlps_pkg::ADDR_W'({r_sweep, tlps_pkg::FLAGS_IDENTITY}) :
                      {r_phys[31:12], r_flags | tlps_pkg::FLAG_PRESENT};
        o_ram_re    = i_ctl.rd;
        o_ram_raddr = i_cmd_data.virt_addr[RAM_AW+11:12];
    end

    assign xl_dir     = r_virt[31:22];
    assign xl_tab     = r_virt[21:12];
    assign xl_off     = r_virt[11:0];
    assign slot_frame = r_tables_frame + tlps_pkg::FRAME_W'(xl_tab);

    always_comb begin
        res = '0;
        case (r_op)
            tlps_pkg::OP_MAP: begin
                res.pages_written = r_written;
            end
            tlps_pkg::OP_XLATE: begin
                if (xl_dir < DIR_LIM) begin
                    res.result_addr = {i_ram_rdata[31:12], xl_off};
                    res.dir_present = 1'b1;
                end else if (xl_dir == tlps_pkg::RECURSIVE_SLOT) begin
                    // Recursive slot: the directory itself is read as a table.
                    res.dir_present = 1'b1;
                    if (xl_tab < DIR_LIM) begin
                        res.result_addr = {slot_frame, xl_off};
                    end else if (xl_tab == tlps_pkg::RECURSIVE_SLOT) begin
                        res.result_addr = {r_dir_frame, xl_off};
                    end else begin
                        res.result_addr = {{tlps_pkg::FRAME_W{1'b0}}, xl_off};
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) r_out <= res;
    end

    assign o_sts.map_done   = (r_left == '0);
    assign o_sts.sweep_last = (r_sweep == SWEEP_LAST);
    assign o_sts.out_free   = ~r_out_valid | i_res_ready;
    assign o_res_valid      = r_out_valid;
    assign o_res_data       = r_out;

endmodule

// ----- hdl/two_level_page_table_store_core.sv -----
// Two-level page table store top level. Translate and no-op: command latched on accept,
// result registered from the hand-off state; the next command waits for that load. Map
// region: one page per cycle. Rebuild: identity sweep of all TABLE_COUNT*1024 entries. A
// stalled result beat delays the next hand-off. Reset (synchronous, active low) clears
// control and config registers, then runs the sweep with cmd not ready; config writes are
// taken outside reset. Depends on tlps_pkg, tlps_if, tlps_ram, tlps_ctrl, tlps_dp.
module two_level_page_table_store_core #(
    parameter int TABLE_COUNT = tlps_pkg::TABLE_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tlps_cmd_if.sink          i_cmd,
    tlps_cfg_if.sink          i_cfg,
    tlps_res_if.source        o_res
);

    localparam int DEPTH  = TABLE_COUNT * tlps_pkg::ENTRIES_PER_TABLE;
    localparam int RAM_AW = $clog2(DEPTH);

    tlps_pkg::t_dp_cmd           dp_cmd;
    tlps_pkg::t_dp_sts           dp_sts;
    logic                        ram_we;
    logic [RAM_AW-1:0]           ram_waddr;
    logic [tlps_pkg::ADDR_W-1:0] ram_wdata;
    logic                        ram_re;
    logic [RAM_AW-1:0]           ram_raddr;
    logic [tlps_pkg::ADDR_W-1:0] ram_rdata;
    logic                        cmd_beat;

    // Config registers are plain flops in the datapath: always ready.
    assign i_cfg.ready = 1'b1;
    assign cmd_beat    = i_cmd.valid & i_cmd.ready;

    // Sequencer: owns cmd ready, walks map/rebuild, hands results to the output register.
    tlps_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (i_cmd.valid),
        .i_cmd_opcode (i_cmd.data.opcode),
        .i_sts        (dp_sts),
        .o_cmd_ready  (i_cmd.ready),
        .o_ctl        (dp_cmd)
    );

    // Datapath: latches the command beat, steps the walk, builds the result beat.
    tlps_dp #(
        .TABLE_COUNT (TABLE_COUNT),
        .RAM_AW      (RAM_AW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_data  (i_cmd.data),
        .i_cfg_we    (i_cfg.valid & i_cfg.ready),
        .i_cfg_data  (i_cfg.data),
        .i_ctl       (dp_cmd),
        .o_sts       (dp_sts),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .i_res_ready (o_res.ready),
        .o_res_valid (o_res.valid),
        .o_res_data  (o_res.data)
    );

    // Page table entries: one write port for sweep and map, one read port for translate.
    tlps_ram #(
        .WIDTH (tlps_pkg::ADDR_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Table writes only happen while the command side is held off.
    a_no_write_while_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !i_cmd.ready)
        else $error("table write while command channel ready");

    // A translate beat reaches the hand-off state on the next cycle.
    a_xlate_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_beat && i_cmd.data.opcode == tlps_pkg::OP_XLATE)
        |=> (dp_cmd.load_out == dp_sts.out_free) && !i_cmd.ready)
        else $error("translate did not reach result hand-off");

    // Never overwrite a result beat that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.load_out |-> dp_sts.out_free)
        else $error("result register overwritten");

    // A result beat only appears after the controller loads one.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(dp_cmd.load_out))
        else $error("result beat without load");

endmodule
